// File: rtl/cvdc_pkg.sv
// Shared types, constants and the direction lookup for the cost vector
// dominance compare block. No dependencies.
`timescale 1ns / 1ps

package cvdc_pkg;

  localparam logic [1:0] DIR_INC = 2'd1;
  localparam logic [1:0] DIR_DEC = 2'd2;
  localparam logic [1:0] DIR_NONE = 2'd0;

  localparam int POS_W = 5;
  localparam logic [POS_W-1:0] POS_MAX = 5'd31;
  localparam int TABLE_ENTRIES = 16;

  localparam int VALUE_W = 32;
  localparam int SUM_W = 33;
  localparam int RESULT_W = 2 * VALUE_W + SUM_W + 2;
  localparam int TDATA_W = ((RESULT_W + 7) / 8) * 8;
  localparam int IN_TDATA_W = 2 * VALUE_W;

  // Running dominance flags carried from element to element.
  typedef struct packed {
    logic no_worse;
    logic seen_better;
  } cvdc_flags_t;

  // One result word; the last field sits in the lowest bits.
  typedef struct packed {
    logic                      strictly_better;
    logic                      no_worse;
    logic signed [SUM_W-1:0]   element_sum;
    logic signed [VALUE_W-1:0] pessimistic_value;
    logic signed [VALUE_W-1:0] optimistic_value;
  } cvdc_result_t;

  // Direction of the element at a given position. Position 0 is the plan
  // length and always increasing; later positions read criterion pos-1.
  function automatic logic [1:0] direction_of(input logic [31:0] table_word,
                                              input logic [POS_W-1:0] pos,
                                              input logic [POS_W-1:0] max_crit);
    logic [POS_W-1:0] k;
    logic [1:0] dir;
    k = pos - 1'b1;
    dir = DIR_NONE;
    if (pos == '0) begin
      dir = DIR_INC;
    end else if ((k < max_crit) && (k < POS_W'(TABLE_ENTRIES))) begin
      dir = table_word[{k[3:0], 1'b0} +: 2];
    end
    return dir;
  endfunction

endpackage

// File: rtl/cost_vector_dominance_compare_top.sv
// Top level of the cost vector dominance compare block: input register,
// running state, per-element logic and output register. Depends on cvdc_pkg,
// cvdc_elem and cvdc_out_reg.
`timescale 1ns / 1ps

// The block compares two cost vectors that arrive one element pair per input
// word, the final pair marked by s_axis_tlast. Each input word yields exactly
// one output word carrying the optimistic and pessimistic combination of the
// pair, their exact 33-bit sum, and the running no-worse and strictly-better
// flags; the flags are final on the word marked by m_axis_tlast, after which
// the running state starts over for the next vector. Element 0 is always
// treated as increasing; element i uses the two-bit direction code of
// criterion i-1 from the direction table (1 increasing, 2 decreasing, other
// codes and criteria past the table or past MAX_CRITERIA are ignored by the
// flags and give zero combinations). The block takes one word per clock
// cycle while the sink keeps up: one input register, then the compare,
// select and add logic feeding a single output register. While a finished
// result waits for the sink, an empty input register can still take one word.
// The direction table must only be written while no word is in flight.

module cost_vector_dominance_compare_top
  import cvdc_pkg::*;
#(
  parameter int MAX_CRITERIA = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration: direction table.
  input  logic                  cfg_wr_en,
  input  logic [31:0]           cfg_wr_data,
  // Input stream. tdata: first_value [31:0], second_value [63:32].
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  input  logic                  s_axis_tlast,
  // Result stream. tdata: optimistic_value [31:0], pessimistic_value [63:32],
  // element_sum [96:64], no_worse [97], strictly_better [98], zeros above.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,
  output logic                  m_axis_tlast
);

  localparam logic [POS_W-1:0] MaxCrit = POS_W'(MAX_CRITERIA);

  logic [31:0] direction_table;

  // Input register stage.
  logic                      s1_valid;
  logic signed [VALUE_W-1:0] s1_first;
  logic signed [VALUE_W-1:0] s1_second;
  logic                      s1_last;
  logic                      out_ready;
  logic                      s1_fire;

  // Running state of the vector being compared.
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] position_next;
  cvdc_flags_t      flags;
  cvdc_flags_t      flags_next;
  cvdc_result_t     elem_result;
  logic [1:0]       dir;

  assign s1_fire = s1_valid & out_ready;
  assign s_axis_tready = ~s1_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction_table <= '0;
    end else if (cfg_wr_en) begin
      direction_table <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_first <= s_axis_tdata[VALUE_W-1:0];
      s1_second <= s_axis_tdata[2*VALUE_W-1:VALUE_W];
      s1_last <= s_axis_tlast;
    end
  end

  assign dir = direction_of(direction_table, position, MaxCrit);

  cvdc_elem u_elem (
    .first_value  (s1_first),
    .second_value (s1_second),
    .dir          (dir),
    .flags_in     (flags),
    .flags_out    (flags_next),
    .result       (elem_result)
  );

  // Position saturates at its top value on overlong vectors.
  assign position_next = (position == POS_MAX) ? position : position + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      flags.no_worse <= 1'b1;
      flags.seen_better <= 1'b0;
    end else if (s1_fire) begin
      if (s1_last) begin
        position <= '0;
        flags.no_worse <= 1'b1;
        flags.seen_better <= 1'b0;
      end else begin
        position <= position_next;
        flags <= flags_next;
      end
    end
  end

  cvdc_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s1_valid),
    .in_ready      (out_ready),
    .in_result     (elem_result),
    .in_last       (s1_last),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: rtl/cvdc_elem.sv
// Per-element compare, select, sum and running flag update.
// Depends on cvdc_pkg.
`timescale 1ns / 1ps

module cvdc_elem
  import cvdc_pkg::*;
(
  input  logic signed [VALUE_W-1:0] first_value,
  input  logic signed [VALUE_W-1:0] second_value,
  input  logic [1:0]                dir,
  input  cvdc_flags_t               flags_in,
  output cvdc_flags_t               flags_out,
  output cvdc_result_t              result
);

  logic gt;
  logic lt;
  logic is_inc;
  logic is_dec;
  logic signed [VALUE_W-1:0] hi;
  logic signed [VALUE_W-1:0] lo;

  assign gt = first_value > second_value;
  assign lt = first_value < second_value;
  assign is_inc = (dir == DIR_INC);
  assign is_dec = (dir == DIR_DEC);
  assign hi = gt ? first_value : second_value;
  assign lo = lt ? first_value : second_value;

  always_comb begin
    flags_out.no_worse = flags_in.no_worse & ~((is_inc & gt) | (is_dec & lt));
    flags_out.seen_better = flags_in.seen_better | (is_inc & lt) | (is_dec & gt);

    result.optimistic_value = '0;
    result.pessimistic_value = '0;
    if (is_inc) begin
      result.optimistic_value = hi;
      result.pessimistic_value = lo;
    end else if (is_dec) begin
      result.optimistic_value = lo;
      result.pessimistic_value = hi;
    end
    result.element_sum = {first_value[VALUE_W-1], first_value}
                       + {second_value[VALUE_W-1], second_value};
    result.no_worse = flags_out.no_worse;
    result.strictly_better = flags_out.no_worse & flags_out.seen_better;
  end

endmodule

// File: rtl/cvdc_out_reg.sv
// Output register of the result stream; holds one word while the sink stalls.
// Depends on cvdc_pkg.
`timescale 1ns / 1ps

module cvdc_out_reg
  import cvdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cvdc_result_t       in_result,
  input  logic               in_last,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic               m_axis_tlast
);

  logic         valid;
  cvdc_result_t result_q;
  logic         last_q;

  assign in_ready = ~valid | m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      result_q <= in_result;
      last_q <= in_last;
    end
  end

  assign m_axis_tvalid = valid;
  assign m_axis_tdata = {{(TDATA_W - RESULT_W){1'b0}}, result_q};
  assign m_axis_tlast = last_q;

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for cost_vector_dominance_compare_top: streams
// directed and random cost vector pairs and checks every result word against
// a cycle-free predictor kept in a scoreboard class. Depends on cvdc_pkg.
`timescale 1ns / 1ps

module tb;
  import cvdc_pkg::*;

  localparam int MAX_CRIT = 16;

  localparam logic signed [31:0] VMIN = 32'sh8000_0000;
  localparam logic signed [31:0] VMAX = 32'sh7fff_ffff;

  localparam logic [31:0] TABLE_MIXED   = 32'h0000_00e4;
  localparam logic [31:0] TABLE_ALL_ONE = 32'hffff_ffff;
  localparam logic [31:0] TABLE_ALL_INC = 32'h5555_5555;
  localparam logic [31:0] TABLE_ALL_DEC = 32'haaaa_aaaa;
  localparam logic [31:0] TABLE_NONE    = 32'h0000_0000;

  // How the element values of a random vector are drawn.
  localparam int VAL_WIDE = 0;
  localparam int VAL_NARROW = 1;
  localparam int VAL_EDGE = 2;
  localparam int VAL_NEAR_EQUAL = 3;

  localparam int PHASES = 8;
  localparam int PHASE_WORDS = 210;

  typedef struct packed {
    cvdc_result_t r;
    logic         last;
  } dominance_word_t;

  // Predicts the result words from the accepted element pairs and checks
  // the words that come out of the block in order.
  class dominance_scoreboard;
    logic [31:0]      dir_table;
    logic [POS_W-1:0] position;
    logic             still_no_worse;
    logic             seen_better;
    dominance_word_t  pending_results[$];
    int               word_count;
    int               mismatches;

    function new();
      dir_table = '0;
      position = '0;
      still_no_worse = 1'b1;
      seen_better = 1'b0;
      word_count = 0;
      mismatches = 0;
    endfunction

    function void set_table(input logic [31:0] value);
      dir_table = value;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function logic [1:0] direction_at();
      int crit;
      crit = int'(position) - 1;
      if (position == '0) begin
        return DIR_INC;
      end
      if (crit >= MAX_CRIT || crit >= TABLE_ENTRIES) begin
        return DIR_NONE;
      end
      return dir_table[2*crit +: 2];
    endfunction

    function void note_pair(input logic signed [31:0] a, input logic signed [31:0] b,
                            input logic last);
      logic [1:0]        dir;
      logic signed [31:0] hi;
      logic signed [31:0] lo;
      dominance_word_t   w;
      dir = direction_at();
      hi = (a >= b) ? a : b;
      lo = (a <= b) ? a : b;
      w = '0;
      if (dir == DIR_INC) begin
        w.r.optimistic_value = hi;
        w.r.pessimistic_value = lo;
        if (a > b) still_no_worse = 1'b0;
        if (a < b) seen_better = 1'b1;
      end else if (dir == DIR_DEC) begin
        w.r.optimistic_value = lo;
        w.r.pessimistic_value = hi;
        if (a < b) still_no_worse = 1'b0;
        if (a > b) seen_better = 1'b1;
      end
      w.r.element_sum = {a[31], a} + {b[31], b};
      w.r.no_worse = still_no_worse;
      w.r.strictly_better = still_no_worse && seen_better;
      w.last = last;
      pending_results.push_back(w);
      // The vector ends here, so the running state starts over.
      if (last) begin
        position = '0;
        still_no_worse = 1'b1;
        seen_better = 1'b0;
      end else if (position != POS_MAX) begin
        position = position + 1'b1;
      end
    endfunction

    function void check_word(input logic [TDATA_W-1:0] data, input logic last);
      dominance_word_t               exp;
      cvdc_result_t                  got;
      logic [TDATA_W-RESULT_W-1:0]   pad;
      got = data[RESULT_W-1:0];
      pad = data[TDATA_W-1:RESULT_W];
      word_count++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result word %0d arrived with nothing expected", word_count);
        end
        return;
      end
      exp = pending_results.pop_front();
      if (got.optimistic_value !== exp.r.optimistic_value ||
          got.pessimistic_value !== exp.r.pessimistic_value ||
          got.element_sum !== exp.r.element_sum ||
          got.no_worse !== exp.r.no_worse ||
          got.strictly_better !== exp.r.strictly_better ||
          last !== exp.last || pad !== '0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("word %0d exp opt=%0d pes=%0d sum=%0d nw=%b sb=%b last=%b",
                   word_count, exp.r.optimistic_value, exp.r.pessimistic_value,
                   exp.r.element_sum, exp.r.no_worse, exp.r.strictly_better, exp.last);
          $display("word %0d got opt=%0d pes=%0d sum=%0d nw=%b sb=%b last=%b pad=%h",
                   word_count, got.optimistic_value, got.pessimistic_value,
                   got.element_sum, got.no_worse, got.strictly_better, last, pad);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_en = 1'b0;
  logic [31:0]           cfg_data = '0;
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [IN_TDATA_W-1:0] s_data = '0;
  logic                  s_last = 1'b0;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [TDATA_W-1:0]    m_data;
  logic                  m_last;

  // When set, neither side inserts gaps or stalls.
  logic calm = 1'b0;

  dominance_scoreboard sb = new();

  cost_vector_dominance_compare_top #(
    .MAX_CRITERIA(MAX_CRIT)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_en),
    .cfg_wr_data   (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tlast  (m_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("tb NOT OK");
    $finish;
  end

  // Sends one element pair and returns at the edge where it was taken.
  task automatic send_pair(input logic signed [31:0] a, input logic signed [31:0] b,
                           input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data <= {b, a};
    s_last <= last;
    do @(posedge clk); while (!s_ready);
    sb.note_pair(a, b, last);
  endtask

  // Holds the input side until every predicted word has come out.
  task automatic drain();
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic load_table(input logic [31:0] value);
    drain();
    cfg_en <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_en <= 1'b0;
    sb.set_table(value);
  endtask

  function automatic logic signed [31:0] pick_value(input int mode);
    case (mode)
      VAL_NARROW: return int'($urandom_range(0, 4)) - 2;
      VAL_EDGE: begin
        case ($urandom_range(0, 6))
          0: return VMIN;
          1: return VMIN + 1;
          2: return -1;
          3: return 0;
          4: return 1;
          5: return VMAX - 1;
          default: return VMAX;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_vector(input int len, input int mode);
    int                 tweak;
    logic signed [31:0] a;
    logic signed [31:0] b;
    tweak = $urandom_range(0, len - 1);
    for (int i = 0; i < len; i++) begin
      if (mode == VAL_NEAR_EQUAL) begin
        // Equal vectors with one element nudged either way, so both flags
        // end up set or cleared often.
        b = int'($urandom_range(0, 1000)) - 500;
        a = b;
        if (i == tweak) a = $urandom_range(0, 1) ? b + 1 : b - 1;
      end else begin
        a = pick_value(mode);
        b = pick_value(mode);
      end
      send_pair(a, b, i == len - 1);
    end
  endtask

  // Result side: random stall before each word, then wait for it.
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_ready <= 1'b1;
      do @(posedge clk); while (!m_valid);
      sb.check_word(m_data, m_last);
    end
  end

  initial begin
    int          sent;
    int          len;
    int          pick;
    logic [31:0] tbl;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset table: only the plan length counts.
    send_pair(VMIN, VMAX, 1'b0);
    send_pair(VMAX, VMIN, 1'b1);

    // Criteria 0..3 carry codes 0, 1, 2 and 3.
    load_table(TABLE_MIXED);
    send_pair(VMIN, VMAX, 1'b1);
    send_pair(VMAX, VMAX, 1'b1);
    send_pair(VMIN, VMIN, 1'b1);
    send_pair(32'sd5, 32'sd3, 1'b1);
    send_pair(32'sd0, 32'sd0, 1'b0);
    send_pair(32'sd7, -32'sd7, 1'b0);
    send_pair(-32'sd1, 32'sd0, 1'b0);
    send_pair(-32'sd1, 32'sd0, 1'b0);
    send_pair(32'sd3, 32'sd3, 1'b1);
    send_pair(32'sd1, 32'sd1, 1'b0);
    send_pair(-32'sd4, 32'sd4, 1'b0);
    send_pair(32'sd2, 32'sd2, 1'b0);
    send_pair(32'sd9, 32'sd4, 1'b1);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: tbl = TABLE_ALL_ONE;
        1: tbl = TABLE_ALL_INC;
        2: tbl = TABLE_ALL_DEC;
        3: tbl = TABLE_NONE;
        default: tbl = $urandom;
      endcase
      load_table(tbl);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        calm = ($urandom_range(0, 7) == 0);
        pick = $urandom_range(0, 9);
        if (pick < 7) len = $urandom_range(1, 17);
        else if (pick < 9) len = $urandom_range(18, 40);
        else len = $urandom_range(1, 3);
        send_vector(len, $urandom_range(0, 3));
        sent += len;
        if ($urandom_range(0, 49) == 0) drain();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
